FILE: src/dpge_pkg.sv
// ---------------------------------------------------------------------------
// dpge_pkg
// Shared types, register indexes and helper functions for the debounced
// pin group encoder.
// ---------------------------------------------------------------------------
package dpge_pkg;

  localparam int PIN_W     = 8;
  localparam int COUNT_W   = 16;
  localparam int PCNT_W    = 4;
  localparam int IDX_W     = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_PINS  = 8;

  localparam logic [IDX_W-1:0] REG_PIN_COUNT      = 3'd0;
  localparam logic [IDX_W-1:0] REG_PULL_UP        = 3'd1;
  localparam logic [IDX_W-1:0] REG_INVERT         = 3'd2;
  localparam logic [IDX_W-1:0] REG_MASK_MODE      = 3'd3;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd4;

  typedef struct packed {
    logic [PCNT_W-1:0]  pin_count;
    logic               pull_up;
    logic               invert;
    logic               mask_mode;
    logic [COUNT_W-1:0] debounce_ticks;
  } cfg_t;

  // pins 0 .. min(pin_count, MAX_PINS, 8) - 1 are in use
  function automatic logic [PIN_W-1:0] used_mask(input logic [PCNT_W-1:0] pc);
    logic [PIN_W-1:0] m;
    m = '0;
    for (int i = 0; i < PIN_W; i++) begin
      m[i] = (i < MAX_PINS) && (PCNT_W'(i) < pc);
    end
    return m;
  endfunction

  function automatic logic [PIN_W-1:0] lowest_plus_one(input logic [PIN_W-1:0] m);
    logic [PIN_W-1:0] r;
    r = '0;
    for (int i = PIN_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = PIN_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

FILE: src/dpge_cfg.sv
// ---------------------------------------------------------------------------
// dpge_cfg
// Configuration register bank, written through a plain write port.
// ---------------------------------------------------------------------------
module dpge_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [dpge_pkg::IDX_W-1:0]       cfg_index,
  input  logic [dpge_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dpge_pkg::cfg_t                   cfg
);
  import dpge_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin_count      <= PCNT_W'(1);
      cfg.pull_up        <= 1'b1;
      cfg.invert         <= 1'b0;
      cfg.mask_mode      <= 1'b0;
      cfg.debounce_ticks <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_PIN_COUNT:      cfg.pin_count      <= cfg_data[PCNT_W-1:0];
        REG_PULL_UP:        cfg.pull_up        <= cfg_data[0];
        REG_INVERT:         cfg.invert         <= cfg_data[0];
        REG_MASK_MODE:      cfg.mask_mode      <= cfg_data[0];
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/dpge_in_reg.sv
// ---------------------------------------------------------------------------
// dpge_in_reg
// Input register: holds one sampled beat until the engine takes it.
// ---------------------------------------------------------------------------
module dpge_in_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dpge_pkg::PIN_W-1:0]    pin_levels,
  input  logic                          take,
  output logic                          s1_valid,
  output logic [dpge_pkg::PIN_W-1:0]    s1_levels
);
  import dpge_pkg::*;

  assign in_ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_levels <= pin_levels;
    end
  end

endmodule

FILE: src/dpge_engine.sv
// ---------------------------------------------------------------------------
// dpge_engine
// Debounce state, active-state mapping, encoding and the result register.
// ---------------------------------------------------------------------------
module dpge_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  dpge_pkg::cfg_t                cfg,
  input  logic                          s1_valid,
  input  logic [dpge_pkg::PIN_W-1:0]    s1_levels,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dpge_pkg::PIN_W-1:0]    value,
  output logic                          settling
);
  import dpge_pkg::*;

  logic [PIN_W-1:0]   previous_levels;
  logic [COUNT_W-1:0] settle_count;
  logic [PIN_W-1:0]   held_states;

  logic [COUNT_W-1:0] settle_count_next;
  logic [PIN_W-1:0]   held_states_next;
  logic [PIN_W-1:0]   used;
  logic [PIN_W-1:0]   changed;
  logic [PIN_W-1:0]   active;

  assign take = s1_valid && (!out_valid || out_ready);

  always_comb begin
    used    = used_mask(cfg.pin_count);
    changed = (s1_levels ^ previous_levels) & used;
    if ((cfg.debounce_ticks != '0) && (changed != '0)) begin
      settle_count_next = cfg.debounce_ticks;
    end else if (settle_count != '0) begin
      settle_count_next = settle_count - COUNT_W'(1);
    end else begin
      settle_count_next = settle_count;
    end
    active = (cfg.pull_up ? ~s1_levels : s1_levels) ^ {PIN_W{cfg.invert}};
    held_states_next = (settle_count_next == '0) ? (active & used) : held_states;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_levels <= '0;
      settle_count    <= '0;
      held_states     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        previous_levels <= s1_levels;
        settle_count    <= settle_count_next;
        held_states     <= held_states_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      value    <= cfg.mask_mode ? held_states_next : lowest_plus_one(held_states_next);
      settling <= (settle_count_next != '0);
    end
  end

endmodule

FILE: src/debounced_pin_group_encoder_unit.sv
// ---------------------------------------------------------------------------
// debounced_pin_group_encoder_unit
// Debounced pin group encoder: settle counter, active mapping, mask or
// lowest-index encoding with a settling flag.
// Path: each input beat passes through the input reg and then the result reg.
// Throughput: one beat per cycle while out_ready stays high; the settle counter
// and held states update as each beat moves from the input to the result register.
// Reset: synchronous; clears both pipeline stages, debounce state and loads
// the register defaults (pin_count 1, pull_up 1, others 0).
// ---------------------------------------------------------------------------
module debounced_pin_group_encoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dpge_pkg::PIN_W-1:0]       pin_levels,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dpge_pkg::PIN_W-1:0]       value,
  output logic                             settling,
  input  logic                             cfg_write_en,
  input  logic [dpge_pkg::IDX_W-1:0]       cfg_index,
  input  logic [dpge_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dpge_pkg::*;

  cfg_t             cfg;
  logic             take;
  logic             s1_valid;
  logic [PIN_W-1:0] s1_levels;

  dpge_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  dpge_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pin_levels (pin_levels),
    .take       (take),
    .s1_valid   (s1_valid),
    .s1_levels  (s1_levels)
  );

  dpge_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_levels (s1_levels),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .settling  (settling)
  );

endmodule

FILE: src/dpge_checker.sv
// ---------------------------------------------------------------------------
// dpge_checker
// Port-level assertions for the debounced pin group encoder, bound to the
// top level.
// ---------------------------------------------------------------------------
module dpge_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dpge_pkg::PIN_W-1:0]    value,
  input logic                          settling
);
  import dpge_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(value) && $stable(settling)))
    else $error("stalled result beat changed or dropped");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("no result beat two cycles after input beat");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind debounced_pin_group_encoder_unit dpge_checker u_dpge_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value),
  .settling  (settling)
);

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the debounced pin group encoder. A driver process
// feeds pin samples from a queue, an in-bench model of the settle counter and
// active mapping predicts each report, and a monitor compares every report
// beat field by field. Registers are rewritten between phases while idle;
// both sides idle at random and the receiver stalls for a long stretch once.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dpge_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RST_CYCLES  = 7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 90;
  localparam int MAX_SHOWN   = 10;
  localparam int N_PHASES    = 12;

  typedef struct packed {
    logic [PIN_W-1:0] value;
    logic             settling;
  } pin_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIN_W-1:0]      pin_levels = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIN_W-1:0]      value;
  logic                  settling;
  logic                  cfg_write_en = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register shadow and encoder state, at reset values
  cfg_t               enc_cfg = '{pin_count: 4'd1, pull_up: 1'b1, invert: 1'b0,
                                  mask_mode: 1'b0, debounce_ticks: '0};
  logic [PIN_W-1:0]   last_pins = '0;
  logic [COUNT_W-1:0] settle_left = '0;
  logic [PIN_W-1:0]   held_active = '0;

  logic [PIN_W-1:0] pending_samples[$];
  pin_report_t      expected_reports[$];

  int send_gap_pct = 31;
  int take_gap_pct = 46;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int samples_sent = 0;
  int reports_seen = 0;
  int settings_used = 1;

  debounced_pin_group_encoder_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin_levels   (pin_levels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .settling     (settling),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic encode_sample(input logic [PIN_W-1:0] pins, output pin_report_t rep);
    int unsigned      n;
    logic [PIN_W-1:0] used;
    logic [PIN_W-1:0] active;
    n = 32'(enc_cfg.pin_count);
    if (n > MAX_PINS) n = MAX_PINS;
    if (n > PIN_W) n = PIN_W;
    used = PIN_W'((16'd1 << n) - 16'd1);
    if (enc_cfg.debounce_ticks != '0 && ((pins ^ last_pins) & used) != '0) begin
      settle_left = enc_cfg.debounce_ticks;
    end else if (settle_left != '0) begin
      settle_left = settle_left - COUNT_W'(1);
    end
    last_pins = pins;
    if (settle_left == '0) begin
      active = enc_cfg.pull_up ? ~pins : pins;
      if (enc_cfg.invert) active = ~active;
      held_active = active & used;
    end
    rep.settling = (settle_left != '0);
    if (enc_cfg.mask_mode) begin
      rep.value = held_active;
    end else begin
      rep.value = '0;
      for (int i = PIN_W - 1; i >= 0; i--) begin
        if (held_active[i]) rep.value = PIN_W'(i + 1);
      end
    end
  endtask

  always @(posedge clk) begin : drive_samples
    pin_report_t rep;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_sample(pin_levels, rep);
        expected_reports.push_back(rep);
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid   <= 1'b1;
          pin_levels <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random gaps, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= take_gap_pct);
    end
  end

  task automatic note_mismatch(input string what, input pin_report_t want);
    fail_count++;
    if (fail_count <= MAX_SHOWN) begin
      $display("[%0t] %s: expected value=%0d settling=%0b, got value=%0d settling=%0b",
               $realtime, what, want.value, want.settling, value, settling);
    end
  endtask

  always @(posedge clk) begin : check_reports
    pin_report_t want;
    if (!rst && out_valid && out_ready) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        note_mismatch("unexpected report beat", '0);
      end else begin
        want = expected_reports.pop_front();
        if (value !== want.value || settling !== want.settling) begin
          note_mismatch("report mismatch", want);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding",
               cycle_count, expected_reports.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_reports.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
  endtask

  // all five registers; narrow ones carry junk in the unused upper bits
  task automatic set_config(input logic [PCNT_W-1:0] pc, input logic pu, input logic inv,
                            input logic mm, input logic [COUNT_W-1:0] db);
    wait_drained();
    write_reg(REG_PIN_COUNT, {12'($urandom), pc});
    write_reg(REG_PULL_UP, {15'($urandom), pu});
    write_reg(REG_INVERT, {15'($urandom), inv});
    write_reg(REG_MASK_MODE, {15'($urandom), mm});
    write_reg(REG_DEBOUNCE_TICKS, db);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    enc_cfg.pin_count      = pc;
    enc_cfg.pull_up        = pu;
    enc_cfg.invert         = inv;
    enc_cfg.mask_mode      = mm;
    enc_cfg.debounce_ticks = db;
    settings_used++;
  endtask

  // stable runs with bounce bursts, level changes and some pure noise
  task automatic queue_pin_activity(input int unsigned count);
    logic [PIN_W-1:0] level;
    int unsigned      k;
    int unsigned      r;
    level = PIN_W'($urandom);
    k = 0;
    while (k < count) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        pending_samples.push_back(PIN_W'($urandom));
        k++;
      end else if (r < 25) begin
        repeat ($urandom_range(1, 4)) begin
          pending_samples.push_back(level ^ PIN_W'($urandom));
          k++;
        end
      end else if (r < 33) begin
        level = PIN_W'($urandom);
        pending_samples.push_back(level);
        k++;
      end else begin
        pending_samples.push_back(level);
        k++;
      end
    end
  endtask

  initial begin
    logic [PCNT_W-1:0]  pc;
    logic [COUNT_W-1:0] db;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: one pin, active low, index report
    pending_samples.push_back(8'h00); pending_samples.push_back(8'hFF);
    pending_samples.push_back(8'h01); pending_samples.push_back(8'hFE);

    set_config(4'd8, 1'b0, 1'b0, 1'b1, 16'd0);
    pending_samples.push_back(8'h00); pending_samples.push_back(8'hFF);
    pending_samples.push_back(8'h80); pending_samples.push_back(8'h01);

    // pin count saturates, inverted pull-up
    set_config(4'd15, 1'b1, 1'b1, 1'b0, 16'd0);
    pending_samples.push_back(8'h80); pending_samples.push_back(8'h00);
    pending_samples.push_back(8'h40);

    // no pins in use: nothing changes, nothing active
    set_config(4'd0, 1'b0, 1'b0, 1'b1, 16'd3);
    pending_samples.push_back(8'hFF); pending_samples.push_back(8'h00);

    // unused pins must not restart the settle count
    set_config(4'd3, 1'b0, 1'b0, 1'b1, 16'd2);
    repeat (4) pending_samples.push_back(8'h07);
    pending_samples.push_back(8'hFF);
    repeat (3) pending_samples.push_back(8'h05);

    // counter keeps running down after debounce is switched off
    set_config(4'd2, 1'b1, 1'b0, 1'b0, 16'd6);
    pending_samples.push_back(8'h02);
    set_config(4'd2, 1'b1, 1'b0, 1'b0, 16'd0);
    repeat (7) pending_samples.push_back(8'h02);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: pc = 4'd8;
        1: pc = 4'd15;
        2: pc = 4'd0;
        3: pc = 4'd1;
        default: pc = PCNT_W'($urandom_range(0, 15));
      endcase
      if (p % 4 == 0) db = '0;
      else if (p == 5) db = 16'd1;
      else db = COUNT_W'($urandom_range(1, 6));
      set_config(pc, 1'($urandom), 1'($urandom), 1'($urandom), db);
      if (p == 4) begin
        send_gap_pct <= 46;
        take_gap_pct <= 31;
      end else if (p == 8) begin
        send_gap_pct <= 0;
        take_gap_pct <= 0;
      end
      queue_pin_activity(60);
      if (p == 2) hold_req <= hold_req + 1;
    end

    // longest debounce: a change keeps the group settling
    set_config(4'd8, 1'b0, 1'b0, 1'b1, 16'hFFFF);
    pending_samples.push_back(8'hA5);
    repeat (20) pending_samples.push_back(8'h5A);

    wait_drained();
    repeat (8) @(posedge clk);
    fail_count += expected_reports.size();
    $display("Covered %0d sample beats and %0d report beats over %0d register settings,",
             samples_sent, reports_seen, settings_used);
    $display("pin counts 0 to 15, both senses, inversion, both forms, debounce to 65535; %0d fails",
             fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
